// ===== sv/stl_pkg.sv =====
// ---------------------------------------------------------------------------
// Symbol table package
// Shared types and constants for the symbol table lookup and insert unit.
// ---------------------------------------------------------------------------
package stl_pkg;

    localparam int TABLE_DEPTH_DEF = 128;
    localparam int NAME_BYTES_DEF  = 16;

    typedef enum logic [1:0] {
        ST_FOUND   = 2'd0,
        ST_CREATED = 2'd1,
        ST_FULL    = 2'd2,
        ST_EMPTY   = 2'd3
    } status_t;

    typedef struct packed {
        logic [63:0] name_high;
        logic [63:0] name_low;
    } req_t;

    typedef struct packed {
        status_t            status;
        logic [6:0]         entry_index;
        logic               entry_kind;
        logic signed [63:0] int_value;
    } rsp_t;

    // Preset lambda names
    localparam logic [63:0] PRESET_LO0 = 64'h2B;
    localparam logic [63:0] PRESET_LO1 = 64'h2A;
    localparam logic [63:0] PRESET_LO2 = 64'h6D616C2D656B616D;
    localparam logic [63:0] PRESET_HI2 = 64'h616462;
    localparam int          PRESET_COUNT = 3;

endpackage

// ===== sv/stl_front.sv =====
// ---------------------------------------------------------------------------
// Symbol table front end
// Accepts names, masks bytes from the terminator on and past NAME_BYTES, queues them for the back end.
// ---------------------------------------------------------------------------
module stl_front
    import stl_pkg::*;
#(
    parameter int NAME_BYTES = NAME_BYTES_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  req_t in_data,
    input  logic push,
    output logic full,
    output req_t q_data,
    output logic q_valid,
    input  logic q_take
);

    logic [127:0] raw;
    logic [127:0] masked;
    logic         alive;
    req_t         slot_reg [2];
    logic [1:0]   cnt_reg;
    logic         rd_reg;
    logic         wr_reg;

    // Keep bytes up to the first zero byte and below NAME_BYTES
    always_comb
    begin
        raw    = {in_data.name_high, in_data.name_low};
        masked = '0;
        alive  = 1'b1;
        for (int i = 0; i < 16; i++)
        begin
            if (raw[8*i +: 8] == 8'd0 || i >= NAME_BYTES)
                alive = 1'b0;
            if (alive)
                masked[8*i +: 8] = raw[8*i +: 8];
        end
    end

    assign full    = cnt_reg[1];
    assign q_valid = cnt_reg != 2'd0;
    assign q_data  = slot_reg[rd_reg];

    // Two-entry queue toward the back end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
        end
        else
        begin
            if (push && !full)
                wr_reg <= ~wr_reg;
            if (q_take && q_valid)
                rd_reg <= ~rd_reg;
            cnt_reg <= cnt_reg + 2'(push && !full) - 2'(q_take && q_valid);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && !full)
            slot_reg[wr_reg] <= '{name_high: masked[127:64], name_low: masked[63:0]};
    end

endmodule

// ===== sv/stl_parse.sv =====
// ---------------------------------------------------------------------------
// Decimal parser
// Converts a name to a saturated 64-bit integer, one character per cycle.
// ---------------------------------------------------------------------------
module stl_parse
    import stl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  req_t        name,
    output logic        done,
    output logic [63:0] value
);

    typedef enum logic [1:0] { P_IDLE, P_BLANK, P_DIGIT, P_DONE } pstate_t;

    pstate_t      state_reg;
    logic [127:0] buf_reg;
    logic [4:0]   pos_reg;
    logic         neg_reg;
    logic [63:0]  acc_reg;
    logic [7:0]   ch;
    logic [3:0]   dig;
    logic [63:0]  limit;
    logic [63:0]  thr;
    logic [67:0]  prod;

    assign ch    = buf_reg[7:0];
    assign dig   = ch[3:0];
    assign limit = neg_reg ? 64'h8000000000000000 : 64'h7FFFFFFFFFFFFFFF;
    // (limit - dig) / 10: the quotient drops by one once dig passes the limit's last digit
    assign thr   = 64'h0CCCCCCCCCCCCCCC - {63'd0, dig > (neg_reg ? 4'd8 : 4'd7)};
    assign prod  = {acc_reg, 3'b000} + {2'b00, acc_reg, 1'b0} + 68'(dig);
    assign done  = state_reg == P_DONE;
    assign value = neg_reg ? (64'd0 - acc_reg) : acc_reg;

    // Walk blanks, sign, then digits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= P_IDLE;
            pos_reg   <= '0;
            neg_reg   <= 1'b0;
            acc_reg   <= '0;
            buf_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                P_IDLE:
                begin
                    if (start)
                    begin
                        buf_reg   <= {name.name_high, name.name_low};
                        pos_reg   <= '0;
                        neg_reg   <= 1'b0;
                        acc_reg   <= '0;
                        state_reg <= P_BLANK;
                    end
                end
                P_BLANK:
                begin
                    if (pos_reg == 5'd16)
                        state_reg <= P_DONE;
                    else if (ch == 8'h20 || (ch >= 8'h09 && ch <= 8'h0D))
                    begin
                        buf_reg <= buf_reg >> 8;
                        pos_reg <= pos_reg + 5'd1;
                    end
                    else
                    begin
                        if (ch == 8'h2B || ch == 8'h2D)
                        begin
                            neg_reg <= ch == 8'h2D;
                            buf_reg <= buf_reg >> 8;
                            pos_reg <= pos_reg + 5'd1;
                        end
                        state_reg <= P_DIGIT;
                    end
                end
                P_DIGIT:
                begin
                    if (pos_reg == 5'd16 || ch < 8'h30 || ch > 8'h39)
                        state_reg <= P_DONE;
                    else
                    begin
                        acc_reg <= (acc_reg > thr) ? limit : prod[63:0];
                        buf_reg <= buf_reg >> 8;
                        pos_reg <= pos_reg + 5'd1;
                    end
                end
                P_DONE:
                    state_reg <= P_IDLE;
                default:
                    state_reg <= P_IDLE;
            endcase
        end
    end

endmodule

// ===== sv/stl_back.sv =====
// ---------------------------------------------------------------------------
// Symbol table back end
// Loads the preset entries, scans the table memory, inserts on a miss when there is room and registers the result.
// ---------------------------------------------------------------------------
module stl_back
    import stl_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  req_t q_data,
    input  logic q_valid,
    output logic q_take,
    output rsp_t rsp,
    output logic empty,
    input  logic pop
);

    localparam int IW = $clog2(TABLE_DEPTH);

    typedef enum logic [2:0] { B_IDLE, B_READ, B_CMP, B_PARSE, B_WRITE, B_OUT } bstate_t;

    typedef struct packed {
        logic [63:0] lo;
        logic [63:0] hi;
        logic        is_int;
        logic [63:0] val;
    } entry_t;

    entry_t        mem [TABLE_DEPTH];
    entry_t        rd_reg;
    bstate_t       state_reg;
    logic [IW:0]   used_reg;
    logic [IW:0]   idx_reg;
    req_t          key_reg;
    rsp_t          rsp_reg;
    logic          out_valid_reg;
    logic          loading;
    logic          pstart;
    logic          pdone;
    logic [63:0]   pval;
    logic          wr_en;
    entry_t        wr_data;

    assign loading = used_reg < (IW+1)'(PRESET_COUNT);
    assign empty  = !out_valid_reg;
    assign rsp    = rsp_reg;
    assign q_take = state_reg == B_IDLE && !loading && q_valid && !out_valid_reg;
    assign pstart = state_reg == B_PARSE && !pdone;
    assign wr_en  = state_reg == B_WRITE;
    // Preset entries are lambdas with a zero value
    assign wr_data = '{lo: key_reg.name_low, hi: key_reg.name_high, is_int: !loading,
                       val: loading ? 64'd0 : pval};

    stl_parse u_parse (
        .clk   (clk),
        .rst_n (rst_n),
        .start (pstart),
        .name  (key_reg),
        .done  (pdone),
        .value (pval)
    );

    // Table memory: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[idx_reg[IW-1:0]] <= wr_data;
        rd_reg <= mem[idx_reg[IW-1:0]];
    end

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            used_reg      <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
            key_reg       <= '0;
            rsp_reg       <= '0;
        end
        else
        begin
            if (pop && out_valid_reg)
                out_valid_reg <= 1'b0;
            case (state_reg)
                B_IDLE:
                begin
                    if (loading)
                    begin
                        // Load the preset lambdas after reset
                        case (used_reg[1:0])
                            2'd0: key_reg <= '{name_high: 64'd0, name_low: PRESET_LO0};
                            2'd1: key_reg <= '{name_high: 64'd0, name_low: PRESET_LO1};
                            default:
                                key_reg <= '{name_high: PRESET_HI2, name_low: PRESET_LO2};
                        endcase
                        idx_reg   <= used_reg;
                        state_reg <= B_WRITE;
                    end
                    else if (q_take)
                    begin
                        key_reg <= q_data;
                        idx_reg <= '0;
                        if (q_data.name_low == 64'd0)
                        begin
                            rsp_reg       <= '{status: ST_EMPTY, default: '0};
                            out_valid_reg <= 1'b1;
                        end
                        else
                            state_reg <= B_READ;
                    end
                end
                B_READ:
                begin
                    if (idx_reg == used_reg)
                    begin
                        if (used_reg == (IW+1)'(TABLE_DEPTH))
                        begin
                            rsp_reg   <= '{status: ST_FULL, default: '0};
                            state_reg <= B_OUT;
                        end
                        else
                            state_reg <= B_PARSE;
                    end
                    else
                        state_reg <= B_CMP;
                end
                B_CMP:
                begin
                    if (rd_reg.lo == key_reg.name_low && rd_reg.hi == key_reg.name_high)
                    begin
                        rsp_reg.status      <= ST_FOUND;
                        rsp_reg.entry_index <= 7'(idx_reg);
                        rsp_reg.entry_kind  <= rd_reg.is_int;
                        rsp_reg.int_value   <= rd_reg.val;
                        state_reg           <= B_OUT;
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= B_READ;
                    end
                end
                B_PARSE:
                begin
                    if (pdone)
                        state_reg <= B_WRITE;
                end
                B_WRITE:
                begin
                    used_reg <= used_reg + 1'b1;
                    if (loading)
                        state_reg <= B_IDLE;
                    else
                    begin
                        rsp_reg.status      <= ST_CREATED;
                        rsp_reg.entry_index <= 7'(idx_reg);
                        rsp_reg.entry_kind  <= 1'b1;
                        rsp_reg.int_value   <= pval;
                        state_reg           <= B_OUT;
                    end
                end
                B_OUT:
                begin
                    out_valid_reg <= 1'b1;
                    state_reg     <= B_IDLE;
                end
                default:
                    state_reg <= B_IDLE;
            endcase
        end
    end

endmodule

// ===== sv/symbol_table_lookup_insert_unit.sv =====
// Symbol table lookup with insert on miss. One item is handled at a time: an
// empty name is answered straight from the idle state; otherwise the back end
// scans the used entries in a one-port table memory, reading then comparing each
// entry, then on a miss with room left parses the name and writes the new entry,
// or else reports a full table. After reset the three lambda entries are written
// before the first item is taken.
// ---------------------------------------------------------------------------
// Symbol table lookup and insert unit
// Queue-style front end feeding a sequential table scan and insert back end.
// ---------------------------------------------------------------------------
module symbol_table_lookup_insert_unit
    import stl_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int NAME_BYTES  = NAME_BYTES_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  req_t in_data,
    input  logic push,
    output logic full,
    output rsp_t out_data,
    output logic empty,
    input  logic pop
);

    req_t q_data;
    logic q_valid;
    logic q_take;

    stl_front #(.NAME_BYTES(NAME_BYTES)) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_data (in_data),
        .push    (push),
        .full    (full),
        .q_data  (q_data),
        .q_valid (q_valid),
        .q_take  (q_take)
    );

    stl_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_data  (q_data),
        .q_valid (q_valid),
        .q_take  (q_take),
        .rsp     (out_data),
        .empty   (empty),
        .pop     (pop)
    );

`ifndef SYNTHESIS
    // Transfer out of the queue only when it holds an item
    a_take_valid: assert property (@(posedge clk) disable iff (!rst_n)
        q_take |-> q_valid) else $error("take from empty queue");

    // A held result stays until popped
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(out_data)))
        else $error("result dropped");

    // Empty-name results carry zero fields
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && out_data.status == ST_EMPTY) |-> out_data.int_value == 64'sd0)
        else $error("empty name with value");
`endif

endmodule
